/* src/pbsp_pkg.sv */
// shared types, codes and constants of the page-backed slot pool allocator
`default_nettype none

package pbsp_pkg;

    // default for the top-level item limit
    localparam int MAX_ITEMS_DEF = 4096;

    // field and datapath widths
    localparam int ITEM_W    = 16;
    localparam int PAGE_W    = 17;
    localparam int COUNT_W   = 13;
    localparam int SLOT_W    = 12;
    localparam int PNUM_W    = 16;
    localparam int CFG_W     = 17;
    localparam int MUL_A_W   = 16;
    localparam int NUM_W     = 33;
    localparam int DIV_STEPS = 33;

    // command codes
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_SETCAP = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    // page action codes
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_COMMIT   = 2'd1;
    localparam logic [1:0] ACT_DECOMMIT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ITEM_SIZE  = 2'd0;
    localparam logic [1:0] REG_PAGE_SIZE  = 2'd1;
    localparam logic [1:0] REG_INIT_ITEMS = 2'd2;
    localparam logic [1:0] REG_MAX_ITEMS  = 2'd3;

    // configuration reset values
    localparam logic [ITEM_W-1:0]  ITEM_SIZE_RST  = 16'd64;
    localparam logic [PAGE_W-1:0]  PAGE_SIZE_RST  = 17'd4096;
    localparam logic [COUNT_W-1:0] INIT_ITEMS_RST = 13'd0;
    localparam logic [COUNT_W-1:0] MAX_ITEMS_RST  = 13'd4096;

    // state limits
    localparam logic [COUNT_W-1:0] LIST_EMPTY = 13'h1FFF;
    localparam logic [COUNT_W-1:0] LIVE_MAX   = 13'h1FFF;
    localparam logic [PNUM_W-1:0]  PAGES_MAX  = 16'hFFFF;

    // input word
    typedef struct packed {
        logic [1:0]         command;
        logic [SLOT_W-1:0]  free_slot;
        logic [COUNT_W-1:0] wanted_items;
    } t_in_word;

    // result word
    typedef struct packed {
        logic               granted;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] live_items;
        logic [COUNT_W-1:0] capacity_items;
        logic [1:0]         page_action;
        logic [PNUM_W-1:0]  page_first;
        logic [PNUM_W-1:0]  page_span;
    } t_out_word;

    // operands of the shared multiply-divide unit: (mul_a * mul_b + addend) / divisor
    typedef struct packed {
        logic [MUL_A_W-1:0] mul_a;
        logic [PAGE_W-1:0]  mul_b;
        logic [PAGE_W-1:0]  addend;
        logic [PAGE_W-1:0]  divisor;
    } t_md_req;

endpackage

`default_nettype wire

/* src/pbsp_muldiv.sv */
// shared multiply-add then restoring divide unit, one quotient bit per cycle
`default_nettype none

module pbsp_muldiv (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire pbsp_pkg::t_md_req         i_req,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [pbsp_pkg::NUM_W-1:0]     o_quot
);

    localparam int NW    = pbsp_pkg::NUM_W;
    localparam int DW    = pbsp_pkg::PAGE_W;
    localparam int CNT_W = $clog2(pbsp_pkg::DIV_STEPS + 1);

    logic [NW-1:0]    r_num;
    logic [DW-1:0]    r_divisor;
    logic [DW-1:0]    r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [NW-1:0]    w_prod;
    logic [DW:0]      w_rem_sh;
    logic             w_fits;
    logic [DW:0]      w_rem_nx;

    // numerator loaded at start
    assign w_prod = NW'(i_req.mul_a) * NW'(i_req.mul_b) + NW'(i_req.addend);

    // one restoring step: shift in the next numerator bit, subtract if it fits
    assign w_rem_sh = {r_rem, r_num[NW-1]};
    assign w_fits   = (w_rem_sh >= {1'b0, r_divisor});
    assign w_rem_nx = w_fits ? (w_rem_sh - {1'b0, r_divisor}) : w_rem_sh;

    // sequencing of the division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num     <= w_prod;
                r_divisor <= i_req.divisor;
                r_rem     <= '0;
                r_cnt     <= CNT_W'(pbsp_pkg::DIV_STEPS);
                r_busy    <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[NW-2:0], w_fits};
                r_rem <= w_rem_nx[DW-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_num;

    // done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("muldiv done held for more than one cycle");

    // step counter stays in range while dividing
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0 && r_cnt <= CNT_W'(pbsp_pkg::DIV_STEPS)))
        else $error("muldiv step counter out of range");

    // done only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("muldiv done without division in progress");

endmodule

`default_nettype wire

/* src/page_backed_slot_pool_allocator.sv */
// top level of the page-backed slot pool allocator
//
// One command word comes in on the input channel (i_in_valid / o_in_stall) and
// gives exactly one result word on the output channel (o_out_valid / i_out_stall).
// Allocate pops the free list or hands out the next never-used slot, growing the
// committed pages when needed; free pushes a slot; set capacity commits or
// decommits pages. Configuration writes on i_cfg_we take effect at once and
// re-initialise the pool. One word is in work at a time; the result sits in an
// output register, so the next word is taken while it waits.
// No-op goes straight to the done state; free and a plain allocate pass through
// their own state first, and an allocate from the free list reads the link memory
// before it pops; set capacity runs the shared unit for the pages wanted and, on a
// commit or decommit, again for the capacity; an allocate that tries to grow runs
// the same steps, then hands out a slot. Each page or capacity figure goes through
// one shared multiply-divide unit: a multiply-add at start, then 33 one-bit divide steps.
// After reset and after every configuration write the block computes the page
// limit, committed pages and capacity with o_in_stall high.
// While the receiver stalls, the result word holds; a finished second word
// waits in the sequencer until the output register frees.
`default_nettype none

module page_backed_slot_pool_allocator #(
    parameter int MAX_ITEMS = pbsp_pkg::MAX_ITEMS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [pbsp_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire pbsp_pkg::t_in_word            i_in_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output pbsp_pkg::t_out_word                o_out_word
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int NW = pbsp_pkg::NUM_W;
    localparam int IW = pbsp_pkg::ITEM_W;
    localparam int PW = pbsp_pkg::PAGE_W;
    localparam int KW = pbsp_pkg::COUNT_W;
    localparam int SW = pbsp_pkg::SLOT_W;
    localparam int GW = pbsp_pkg::PNUM_W;
    localparam int MW = pbsp_pkg::MUL_A_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM_GO,
        ST_LIM_WT,
        ST_COM_GO,
        ST_COM_WT,
        ST_CAP_GO,
        ST_CAP_WT,
        ST_WANT_GO,
        ST_WANT_WT,
        ST_POP_RD,
        ST_POP,
        ST_FREE,
        ST_BUMP,
        ST_DONE
    } t_state;

    // configuration
    logic [IW-1:0] r_item_size;
    logic [PW-1:0] r_page_size;
    logic [KW-1:0] r_init_items;
    logic [KW-1:0] r_max_items;

    // pool state
    logic [KW-1:0] r_free_head;
    logic [KW-1:0] r_bump;
    logic [KW-1:0] r_live;
    logic [GW-1:0] r_pages_committed;
    logic [GW-1:0] r_pages_limit;
    logic [CW-1:0] r_slot_capacity;
    logic [KW-1:0] r_link_mem [0:(1 << SW)-1];
    logic [KW-1:0] r_link_rd;

    // sequencer and word in work
    t_state        r_state;
    logic          r_is_init;
    logic [1:0]    r_cmd;
    logic [SW-1:0] r_free_slot;
    logic [KW:0]   r_n;
    logic          r_granted;
    logic [SW-1:0] r_slot;
    logic [1:0]    r_act;
    logic [GW-1:0] r_first;
    logic [GW-1:0] r_count;

    // output register
    logic                r_out_valid;
    pbsp_pkg::t_out_word r_out_word;

    logic [PW-1:0]     w_eff_item;
    logic [PW-1:0]     w_eff_page;
    logic [KW:0]       w_grow;
    logic              w_accept;
    logic              w_out_load;
    logic              w_md_start;
    logic              w_md_busy;
    logic              w_md_done;
    logic [NW-1:0]     w_md_quot;
    pbsp_pkg::t_md_req w_md_req;

    // zero sizes count as one
    assign w_eff_item = (r_item_size == '0) ? PW'(1) : PW'(r_item_size);
    assign w_eff_page = (r_page_size == '0) ? PW'(1) : r_page_size;

    // growth target: live * 3 / 2
    assign w_grow = (KW + 1)'(((KW + 2)'(r_live) + (KW + 2)'({r_live, 1'b0})) >> 1);

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // operand select for the shared unit
    always_comb begin
        w_md_start       = 1'b0;
        w_md_req.mul_a   = '0;
        w_md_req.mul_b   = w_eff_item;
        w_md_req.addend  = w_eff_page - PW'(1);
        w_md_req.divisor = w_eff_page;
        case (r_state)
            ST_LIM_GO: begin
                w_md_start     = 1'b1;
                w_md_req.mul_a = MW'(r_max_items);
            end
            ST_COM_GO: begin
                w_md_start     = 1'b1;
                w_md_req.mul_a = MW'(r_init_items);
            end
            ST_WANT_GO: begin
                w_md_start     = 1'b1;
                w_md_req.mul_a = MW'(r_n);
            end
            ST_CAP_GO: begin
                w_md_start       = 1'b1;
                w_md_req.mul_a   = r_pages_committed;
                w_md_req.mul_b   = w_eff_page;
                w_md_req.addend  = '0;
                w_md_req.divisor = w_eff_item;
            end
            default: begin
                w_md_start = 1'b0;
            end
        endcase
    end

    pbsp_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_req   (w_md_req),
        .o_busy  (w_md_busy),
        .o_done  (w_md_done),
        .o_quot  (w_md_quot)
    );

    // link memory: push on free, registered read at the list head
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FREE) begin
            r_link_mem[r_free_slot] <= r_free_head;
        end
        r_link_rd <= r_link_mem[r_free_head[SW-1:0]];
    end

    // sequencer, pool state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_size       <= pbsp_pkg::ITEM_SIZE_RST;
            r_page_size       <= pbsp_pkg::PAGE_SIZE_RST;
            r_init_items      <= pbsp_pkg::INIT_ITEMS_RST;
            r_max_items       <= pbsp_pkg::MAX_ITEMS_RST;
            r_free_head       <= pbsp_pkg::LIST_EMPTY;
            r_bump            <= '0;
            r_live            <= pbsp_pkg::INIT_ITEMS_RST;
            r_pages_committed <= '0;
            r_pages_limit     <= '0;
            r_slot_capacity   <= '0;
            r_state           <= ST_LIM_GO;
            r_is_init         <= 1'b1;
            r_out_valid       <= 1'b0;
        end else begin
            // output register handshake
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_word  <= '{
                    granted:        r_granted,
                    slot_index:     r_slot,
                    live_items:     r_live,
                    capacity_items: KW'(r_slot_capacity),
                    page_action:    r_act,
                    page_first:     r_first,
                    page_span:      r_count
                };
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                // configuration write re-initialises the pool
                case (i_cfg_index)
                    pbsp_pkg::REG_ITEM_SIZE:  r_item_size  <= i_cfg_data[IW-1:0];
                    pbsp_pkg::REG_PAGE_SIZE:  r_page_size  <= i_cfg_data[PW-1:0];
                    pbsp_pkg::REG_INIT_ITEMS: r_init_items <= i_cfg_data[KW-1:0];
                    pbsp_pkg::REG_MAX_ITEMS:  r_max_items  <= i_cfg_data[KW-1:0];
                    default:                  r_item_size  <= r_item_size;
                endcase
                r_free_head <= pbsp_pkg::LIST_EMPTY;
                r_bump      <= '0;
                r_live      <= (i_cfg_index == pbsp_pkg::REG_INIT_ITEMS) ?
                               i_cfg_data[KW-1:0] : r_init_items;
                r_is_init   <= 1'b1;
                r_state     <= ST_LIM_GO;
            end else begin
                case (r_state)
                    ST_IDLE: begin
                        if (w_accept) begin
                            r_cmd       <= i_in_word.command;
                            r_free_slot <= i_in_word.free_slot;
                            r_granted   <= 1'b0;
                            r_slot      <= '0;
                            r_act       <= pbsp_pkg::ACT_NONE;
                            r_first     <= '0;
                            r_count     <= '0;
                            case (i_in_word.command)
                                pbsp_pkg::CMD_ALLOC: begin
                                    if (r_free_head != pbsp_pkg::LIST_EMPTY) begin
                                        r_state <= ST_POP_RD;
                                    end else if ((PW + 1)'(r_bump) >=
                                                 (PW + 1)'(r_slot_capacity)) begin
                                        r_n     <= w_grow;
                                        r_state <= ST_WANT_GO;
                                    end else begin
                                        r_state <= ST_BUMP;
                                    end
                                end
                                pbsp_pkg::CMD_FREE: begin
                                    r_state <= ST_FREE;
                                end
                                pbsp_pkg::CMD_SETCAP: begin
                                    r_n     <= (KW + 1)'(i_in_word.wanted_items);
                                    r_state <= ST_WANT_GO;
                                end
                                default: begin
                                    r_state <= ST_DONE;
                                end
                            endcase
                        end
                    end
                    // page limit for max_items
                    ST_LIM_GO: begin
                        r_state <= ST_LIM_WT;
                    end
                    ST_LIM_WT: begin
                        if (w_md_done) begin
                            r_pages_limit <= (w_md_quot > NW'(pbsp_pkg::PAGES_MAX)) ?
                                             pbsp_pkg::PAGES_MAX : w_md_quot[GW-1:0];
                            r_state       <= ST_COM_GO;
                        end
                    end
                    // committed pages for initial_items, capped at the limit
                    ST_COM_GO: begin
                        r_state <= ST_COM_WT;
                    end
                    ST_COM_WT: begin
                        if (w_md_done) begin
                            r_pages_committed <= (w_md_quot > NW'(r_pages_limit)) ?
                                                 r_pages_limit : w_md_quot[GW-1:0];
                            r_state           <= ST_CAP_GO;
                        end
                    end
                    // capacity from committed pages, saturated
                    ST_CAP_GO: begin
                        r_state <= ST_CAP_WT;
                    end
                    ST_CAP_WT: begin
                        if (w_md_done) begin
                            r_slot_capacity <= (w_md_quot > NW'(MAX_ITEMS)) ?
                                               CW'(MAX_ITEMS) : w_md_quot[CW-1:0];
                            if (r_is_init) begin
                                r_is_init <= 1'b0;
                                r_state   <= ST_IDLE;
                            end else if (r_cmd == pbsp_pkg::CMD_ALLOC) begin
                                r_state <= ST_BUMP;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                    end
                    // pages wanted for the requested count, then grow or shrink
                    ST_WANT_GO: begin
                        r_state <= ST_WANT_WT;
                    end
                    ST_WANT_WT: begin
                        if (w_md_done) begin
                            if (r_n > (KW + 1)'(r_live) &&
                                w_md_quot > NW'(r_pages_committed) &&
                                w_md_quot <= NW'(r_pages_limit)) begin
                                r_act             <= pbsp_pkg::ACT_COMMIT;
                                r_first           <= r_pages_committed;
                                r_count           <= w_md_quot[GW-1:0] - r_pages_committed;
                                r_pages_committed <= w_md_quot[GW-1:0];
                                r_state           <= ST_CAP_GO;
                            end else if (r_n < (KW + 1)'(r_live) &&
                                         w_md_quot < NW'(r_pages_committed)) begin
                                r_act             <= pbsp_pkg::ACT_DECOMMIT;
                                r_first           <= w_md_quot[GW-1:0];
                                r_count           <= r_pages_committed - w_md_quot[GW-1:0];
                                r_pages_committed <= w_md_quot[GW-1:0];
                                r_state           <= ST_CAP_GO;
                            end else if (r_cmd == pbsp_pkg::CMD_ALLOC) begin
                                r_state <= ST_BUMP;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                    end
                    // pop the free list head
                    ST_POP_RD: begin
                        r_state <= ST_POP;
                    end
                    ST_POP: begin
                        r_granted   <= 1'b1;
                        r_slot      <= r_free_head[SW-1:0];
                        r_free_head <= r_link_rd;
                        if (r_live != pbsp_pkg::LIVE_MAX) begin
                            r_live <= r_live + KW'(1);
                        end
                        r_state <= ST_DONE;
                    end
                    // push the returned slot
                    ST_FREE: begin
                        r_free_head <= KW'(r_free_slot);
                        if (r_live != '0) begin
                            r_live <= r_live - KW'(1);
                        end
                        r_state <= ST_DONE;
                    end
                    // hand out the next never-used slot if backed
                    ST_BUMP: begin
                        if ((PW + 1)'(r_bump) < (PW + 1)'(r_slot_capacity)) begin
                            r_granted <= 1'b1;
                            r_slot    <= r_bump[SW-1:0];
                            r_bump    <= r_bump + KW'(1);
                            if (r_live != pbsp_pkg::LIVE_MAX) begin
                                r_live <= r_live + KW'(1);
                            end
                        end
                        r_state <= ST_DONE;
                    end
                    // wait for room in the output register
                    ST_DONE: begin
                        if (w_out_load) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a reported page range is never empty, and no range without an action
    a_act_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_word.page_action == pbsp_pkg::ACT_NONE) ==
                         (r_out_word.page_span == '0)))
        else $error("page action and page count disagree");

    // committed pages never exceed the limit between commands
    a_commit_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pages_committed <= r_pages_limit))
        else $error("committed pages above the page limit");

    // capacity stays saturated
    a_cap_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_capacity <= CW'(MAX_ITEMS))
        else $error("slot capacity above the item limit");

    // a granted slot always leaves at least one live item
    a_grant_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.granted) |-> (r_out_word.live_items != '0))
        else $error("slot granted with no live item");

    // the shared unit is never restarted by a command while busy
    a_md_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_md_start && !r_is_init) |-> !w_md_busy)
        else $error("multiply-divide unit restarted mid operation");

endmodule

`default_nettype wire
